FILE: hdl/swmc_pkg.sv
`timescale 1ns / 1ps
package swmc_pkg;

    localparam int MaxNodesDefault = 256;
    localparam int QHalfPi         = 102944;
    localparam int QPi             = 205887;
    localparam int CordicGain      = 39797;
    localparam int CordicIters     = 16;

    // Input item as it travels through the front queue
    typedef struct packed {
        logic        first_node;
        logic [8:0]  parent_index;
        logic        euler_order;
        logic [15:0] rot_x;
        logic [15:0] rot_y;
        logic [15:0] rot_z;
        logic [23:0] scale_x;
        logic [23:0] scale_y;
        logic [23:0] scale_z;
        logic [31:0] trans_x;
        logic [31:0] trans_y;
        logic [31:0] trans_z;
    } node_item_t;

    // CORDIC arctangent table, Q.16
    function automatic logic signed [31:0] atan_q16(input logic [3:0] i);
        case (i)
            4'd0:    atan_q16 = 32'sd51472;
            4'd1:    atan_q16 = 32'sd30386;
            4'd2:    atan_q16 = 32'sd16055;
            4'd3:    atan_q16 = 32'sd8150;
            4'd4:    atan_q16 = 32'sd4091;
            4'd5:    atan_q16 = 32'sd2047;
            4'd6:    atan_q16 = 32'sd1024;
            4'd7:    atan_q16 = 32'sd512;
            4'd8:    atan_q16 = 32'sd256;
            4'd9:    atan_q16 = 32'sd128;
            4'd10:   atan_q16 = 32'sd64;
            4'd11:   atan_q16 = 32'sd32;
            4'd12:   atan_q16 = 32'sd16;
            4'd13:   atan_q16 = 32'sd8;
            4'd14:   atan_q16 = 32'sd4;
            default: atan_q16 = 32'sd2;
        endcase
    endfunction

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

FILE: hdl/swmc_front.sv
`timescale 1ns / 1ps
// Input side: takes transfers into a two-entry queue
module swmc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  swmc_pkg::node_item_t in_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output swmc_pkg::node_item_t q_item
);
    import swmc_pkg::*;

    node_item_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2) else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> !push) else $error("push into full queue");
endmodule

FILE: hdl/swmc_back.sv
`timescale 1ns / 1ps
// Work side: CORDIC, local matrix, parent product, storage and column output.
// One shared multiplier and one CORDIC stage are stepped by a sequencer.
module swmc_back #(
    parameter int MAX_NODES = swmc_pkg::MaxNodesDefault
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  swmc_pkg::node_item_t q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_node,
    output logic [1:0]           out_col,
    output logic [31:0]          out_x,
    output logic [31:0]          out_y,
    output logic [31:0]          out_z,
    output logic                 out_last
);
    import swmc_pkg::*;

    localparam int Span    = (MAX_NODES < 256) ? MAX_NODES : 256;
    localparam int Depth   = MAX_NODES * 12;
    localparam int AddrW   = $clog2(Depth);

    typedef enum logic [3:0] {
        S_IDLE, S_FOLD, S_CORD, S_LOC, S_SCALE, S_PRD, S_PWAIT, S_WMUL,
        S_WSTORE, S_EMIT
    } state_t;

    state_t             state_reg;
    node_item_t         item_reg;
    logic [7:0]         counter_reg;
    logic [7:0]         node_reg;
    logic [1:0]         ang_reg;
    logic [3:0]         it_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic               fold_reg;
    logic signed [31:0] cs_reg [3];
    logic signed [31:0] sn_reg [3];
    logic [4:0]         step_reg;
    logic signed [31:0] loc_reg [12];
    logic signed [31:0] par_reg [12];
    logic signed [31:0] wld_reg [12];
    logic signed [63:0] acc_reg;
    logic               is_child_reg;
    logic [1:0]         col_reg;
    logic [1:0]         kk_reg;
    logic [1:0]         row_reg;
    logic [3:0]         rd_cnt_reg;
    logic               out_valid_reg;

    logic signed [31:0] store [Depth];
    logic signed [31:0] rd_data_reg;
    logic [AddrW-1:0]   rd_addr;
    logic [AddrW-1:0]   wr_addr;
    logic               wr_en;
    logic signed [31:0] wr_data;

    // Shared multiplier
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [31:0] mul_q;
    assign mul_p = mul_a * mul_b;
    assign mul_q = sat32(mul_p >>> 16);

    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_node  = node_reg;
    assign out_col   = col_reg;
    assign out_x     = wld_reg[{2'b00, col_reg} * 4'd3];
    assign out_y     = wld_reg[{2'b00, col_reg} * 4'd3 + 4'd1];
    assign out_z     = wld_reg[{2'b00, col_reg} * 4'd3 + 4'd2];
    assign out_last  = (col_reg == 2'd3);

    // Local-matrix program: each step is one saturated product
    // temps t0 = a, t1 = b are held in ta_reg and tb_reg
    logic signed [31:0] ta_reg, tb_reg;
    logic signed [31:0] s0, s1, s2, c0, c1, c2;
    assign c0 = cs_reg[0]; assign c1 = cs_reg[1]; assign c2 = cs_reg[2];
    assign s0 = sn_reg[0]; assign s1 = sn_reg[1]; assign s2 = sn_reg[2];

    function automatic logic signed [31:0] negs(input logic signed [31:0] a);
        negs = sat32(-{{32{a[31]}}, a});
    endfunction
    function automatic logic signed [31:0] adds(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        adds = sat32({{32{a[31]}}, a} + {{32{b[31]}}, b});
    endfunction

    // Operand select for the multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_LOC: begin
                if (item_reg.euler_order) begin
                    case (step_reg)
                        5'd0:  begin mul_a = s0; mul_b = s1; end
                        5'd1:  begin mul_a = c0; mul_b = s1; end
                        5'd2:  begin mul_a = c1; mul_b = c2; end
                        5'd3:  begin mul_a = c1; mul_b = s2; end
                        5'd4:  begin mul_a = ta_reg; mul_b = c2; end
                        5'd5:  begin mul_a = c0; mul_b = s2; end
                        5'd6:  begin mul_a = ta_reg; mul_b = s2; end
                        5'd7:  begin mul_a = c0; mul_b = c2; end
                        5'd8:  begin mul_a = s0; mul_b = c1; end
                        5'd9:  begin mul_a = tb_reg; mul_b = c2; end
                        5'd10: begin mul_a = s0; mul_b = s2; end
                        5'd11: begin mul_a = tb_reg; mul_b = s2; end
                        5'd12: begin mul_a = s0; mul_b = c2; end
                        default: begin mul_a = c0; mul_b = c1; end
                    endcase
                end else begin
                    case (step_reg)
                        5'd0:  begin mul_a = c2; mul_b = s1; end
                        5'd1:  begin mul_a = s2; mul_b = s1; end
                        5'd2:  begin mul_a = c2; mul_b = c1; end
                        5'd3:  begin mul_a = s2; mul_b = c1; end
                        5'd4:  begin mul_a = s2; mul_b = c0; end
                        5'd5:  begin mul_a = ta_reg; mul_b = s0; end
                        5'd6:  begin mul_a = c2; mul_b = c0; end
                        5'd7:  begin mul_a = tb_reg; mul_b = s0; end
                        5'd8:  begin mul_a = c1; mul_b = s0; end
                        5'd9:  begin mul_a = s2; mul_b = s0; end
                        5'd10: begin mul_a = ta_reg; mul_b = c0; end
                        5'd11: begin mul_a = c2; mul_b = s0; end
                        5'd12: begin mul_a = tb_reg; mul_b = c0; end
                        default: begin mul_a = c1; mul_b = c0; end
                    endcase
                end
            end
            S_SCALE: begin
                mul_a = loc_reg[step_reg[3:0]];
                case (step_reg)
                    5'd0, 5'd1, 5'd2: mul_b = {{8{item_reg.scale_x[23]}}, item_reg.scale_x};
                    5'd3, 5'd4, 5'd5: mul_b = {{8{item_reg.scale_y[23]}}, item_reg.scale_y};
                    default:          mul_b = {{8{item_reg.scale_z[23]}}, item_reg.scale_z};
                endcase
            end
            S_WMUL: begin
                mul_a = par_reg[{2'b00, kk_reg} * 4'd3 + {2'b00, row_reg}];
                mul_b = loc_reg[{2'b00, col_reg} * 4'd3 + {2'b00, kk_reg}];
            end
            default: ;
        endcase
    end

    // Store address for parent fetch and result write
    logic [AddrW-1:0] pbase, nbase;
    assign pbase   = AddrW'(item_reg.parent_index[7:0]) * AddrW'(12);
    assign nbase   = AddrW'(node_reg) * AddrW'(12);
    assign rd_addr = pbase + AddrW'(rd_cnt_reg);
    assign wr_addr = nbase + AddrW'(step_reg[3:0]);
    assign wr_data = wld_reg[step_reg[3:0]];
    assign wr_en   = (state_reg == S_WSTORE);

    always_ff @(posedge aclk) begin
        if (wr_en) store[wr_addr] <= wr_data;
        rd_data_reg <= store[rd_addr];
    end

    logic signed [31:0] atn;
    assign atn = atan_q16(it_reg);

    logic [7:0] node_now;
    always_comb begin
        node_now = q_item.first_node ? 8'd0 : counter_reg;
        if ({1'b0, node_now} >= 9'(Span)) node_now = 8'd0;
    end

    logic signed [31:0] ang;
    always_comb begin
        case (ang_reg)
            2'd0:    ang = {{13{item_reg.rot_x[15]}}, item_reg.rot_x, 3'b000};
            2'd1:    ang = {{13{item_reg.rot_y[15]}}, item_reg.rot_y, 3'b000};
            default: ang = {{13{item_reg.rot_z[15]}}, item_reg.rot_z, 3'b000};
        endcase
    end

    logic signed [31:0] prod_loc;
    assign prod_loc = mul_q;

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            counter_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        item_reg  <= q_item;
                        node_reg  <= node_now;
                        ang_reg   <= 2'd0;
                        state_reg <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    cx_reg <= 32'(CordicGain);
                    cy_reg <= '0;
                    it_reg <= 4'd0;
                    if (ang > 32'(QHalfPi)) begin
                        cz_reg <= ang - 32'(QPi); fold_reg <= 1'b1;
                    end else if (ang < -32'(QHalfPi)) begin
                        cz_reg <= ang + 32'(QPi); fold_reg <= 1'b1;
                    end else begin
                        cz_reg <= ang; fold_reg <= 1'b0;
                    end
                    state_reg <= S_CORD;
                end
                S_CORD: begin
                    if (!cz_reg[31]) begin
                        cx_reg <= cx_reg - (cy_reg >>> it_reg);
                        cy_reg <= cy_reg + (cx_reg >>> it_reg);
                        cz_reg <= cz_reg - atn;
                    end else begin
                        cx_reg <= cx_reg + (cy_reg >>> it_reg);
                        cy_reg <= cy_reg - (cx_reg >>> it_reg);
                        cz_reg <= cz_reg + atn;
                    end
                    it_reg <= it_reg + 4'd1;
                    if (it_reg == 4'(CordicIters - 1)) begin
                        state_reg <= S_PRD;
                    end
                end
                S_PRD: begin
                    // fold negates both; the used sine is negated again
                    cs_reg[ang_reg] <= fold_reg ? -cx_reg : cx_reg;
                    sn_reg[ang_reg] <= fold_reg ? cy_reg : -cy_reg;
                    if (ang_reg == 2'd2) begin
                        step_reg  <= 5'd0;
                        state_reg <= S_LOC;
                    end else begin
                        ang_reg   <= ang_reg + 2'd1;
                        state_reg <= S_FOLD;
                    end
                end
                S_LOC: begin
                    step_reg <= (step_reg == 5'd13) ? 5'd0 : step_reg + 5'd1;
                    if (item_reg.euler_order) begin
                        case (step_reg)
                            5'd0:  ta_reg <= prod_loc;
                            5'd1:  tb_reg <= prod_loc;
                            5'd2:  loc_reg[0] <= prod_loc;
                            5'd3:  begin loc_reg[3] <= negs(prod_loc);
                                         loc_reg[6] <= negs(s1); end
                            5'd4:  loc_reg[1] <= negs(prod_loc);
                            5'd5:  loc_reg[1] <= adds(loc_reg[1], prod_loc);
                            5'd6:  loc_reg[4] <= prod_loc;
                            5'd7:  loc_reg[4] <= adds(loc_reg[4], prod_loc);
                            5'd8:  loc_reg[7] <= negs(prod_loc);
                            5'd9:  loc_reg[2] <= prod_loc;
                            5'd10: loc_reg[2] <= adds(loc_reg[2], prod_loc);
                            5'd11: loc_reg[5] <= negs(prod_loc);
                            5'd12: loc_reg[5] <= adds(loc_reg[5], prod_loc);
                            default: loc_reg[8] <= prod_loc;
                        endcase
                    end else begin
                        case (step_reg)
                            5'd0:  ta_reg <= negs(prod_loc);
                            5'd1:  tb_reg <= negs(prod_loc);
                            5'd2:  loc_reg[0] <= prod_loc;
                            5'd3:  begin loc_reg[1] <= prod_loc; loc_reg[2] <= s1; end
                            5'd4:  loc_reg[3] <= negs(prod_loc);
                            5'd5:  loc_reg[3] <= adds(loc_reg[3], prod_loc);
                            5'd6:  loc_reg[4] <= prod_loc;
                            5'd7:  loc_reg[4] <= adds(loc_reg[4], prod_loc);
                            5'd8:  loc_reg[5] <= prod_loc;
                            5'd9:  loc_reg[6] <= prod_loc;
                            5'd10: loc_reg[6] <= adds(loc_reg[6], prod_loc);
                            5'd11: loc_reg[7] <= negs(prod_loc);
                            5'd12: loc_reg[7] <= adds(loc_reg[7], prod_loc);
                            default: loc_reg[8] <= prod_loc;
                        endcase
                    end
                    if (step_reg == 5'd13) begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    loc_reg[step_reg[3:0]] <= prod_loc;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd8) begin
                        loc_reg[9]   <= item_reg.trans_x;
                        loc_reg[10]  <= item_reg.trans_y;
                        loc_reg[11]  <= item_reg.trans_z;
                        is_child_reg <= !item_reg.parent_index[8] &&
                                        (item_reg.parent_index[7:0] < node_reg);
                        rd_cnt_reg   <= 4'd0;
                        state_reg    <= S_PWAIT;
                    end
                end
                S_PWAIT: begin
                    // store read is registered: fetch 12 parent words
                    rd_cnt_reg <= rd_cnt_reg + 4'd1;
                    if (rd_cnt_reg != 4'd0) par_reg[rd_cnt_reg - 4'd1] <= rd_data_reg;
                    if (!is_child_reg) begin
                        for (int i = 0; i < 12; i++) wld_reg[i] <= loc_reg[i];
                        step_reg  <= 5'd0;
                        state_reg <= S_WSTORE;
                    end else if (rd_cnt_reg == 4'd12) begin
                        col_reg <= 2'd0; row_reg <= 2'd0; kk_reg <= 2'd0;
                        acc_reg <= '0;
                        state_reg <= S_WMUL;
                    end
                end
                S_WMUL: begin
                    if (kk_reg == 2'd2) begin
                        wld_reg[{2'b00, col_reg} * 4'd3 + {2'b00, row_reg}] <= sat32(
                            acc_reg + (mul_p >>> 16) +
                            ((col_reg == 2'd3) ?
                             $signed({{32{par_reg[4'd9 + {2'b00, row_reg}][31]}},
                                      par_reg[4'd9 + {2'b00, row_reg}]}) : 64'sd0));
                        acc_reg <= '0;
                        kk_reg  <= 2'd0;
                        if (row_reg == 2'd2) begin
                            row_reg <= 2'd0;
                            if (col_reg == 2'd3) begin
                                step_reg  <= 5'd0;
                                state_reg <= S_WSTORE;
                            end
                            col_reg <= col_reg + 2'd1;
                        end else begin
                            row_reg <= row_reg + 2'd1;
                        end
                    end else begin
                        acc_reg <= acc_reg + (mul_p >>> 16);
                        kk_reg  <= kk_reg + 2'd1;
                    end
                end
                S_WSTORE: begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd11) begin
                        col_reg       <= 2'd0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_ready) begin
                        col_reg <= col_reg + 2'd1;
                        if (col_reg == 2'd3) begin
                            out_valid_reg <= 1'b0;
                            counter_reg   <= ({1'b0, node_reg} + 9'd1 >= 9'(Span)) ?
                                             8'd0 : node_reg + 8'd1;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_valid_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (state_reg == S_EMIT)) else $error("output outside emit");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_ready && state_reg != S_IDLE) |-> 1'b0) else $error("take while busy");
    a_last_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_ready && out_last) |=> !out_valid)
        else $error("emit continues after last column");
endmodule

FILE: hdl/skeleton_world_matrix_compose_unit.sv
`timescale 1ns / 1ps
// Skeleton world-matrix composer. Nodes arrive in tree order; each yields four
// column transfers (axes 0..2, then translation with tlast). A root node takes
// three 16-step CORDIC passes with a fold and a write-back step each, then 23
// products on one shared multiplier, a 12-word store write and four output
// transfers, plus any output stalls. A node with a valid parent adds a 12-word
// parent fetch through the world store and 36 multiply-accumulate steps.
// A two-entry input queue takes transfers while a node is being worked.
module skeleton_world_matrix_compose_unit #(
    parameter int MAX_NODES = swmc_pkg::MaxNodesDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_node, parent_index, euler_order, rot_x, rot_y, rot_z, scale_x,
    // scale_y, scale_z, trans_x, trans_y, trans_z; zero pad to 232 bits
    input  logic [231:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // node_number, column_index, elem_x, elem_y, elem_z; zero pad to 112 bits
    output logic [111:0] m_tdata,
    output logic         m_tlast
);
    import swmc_pkg::*;

    node_item_t         in_item, q_item;
    logic               q_valid, q_ready;
    logic [7:0]         o_node;
    logic [1:0]         o_col;
    logic [31:0]        o_x, o_y, o_z;

    assign in_item.first_node   = s_tdata[0];
    assign in_item.parent_index = s_tdata[9:1];
    assign in_item.euler_order  = s_tdata[10];
    assign in_item.rot_x        = s_tdata[26:11];
    assign in_item.rot_y        = s_tdata[42:27];
    assign in_item.rot_z        = s_tdata[58:43];
    assign in_item.scale_x      = s_tdata[82:59];
    assign in_item.scale_y      = s_tdata[106:83];
    assign in_item.scale_z      = s_tdata[130:107];
    assign in_item.trans_x      = s_tdata[162:131];
    assign in_item.trans_y      = s_tdata[194:163];
    assign in_item.trans_z      = s_tdata[226:195];

    swmc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    swmc_back #(.MAX_NODES(MAX_NODES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_node(o_node), .out_col(o_col),
        .out_x(o_x), .out_y(o_y), .out_z(o_z), .out_last(m_tlast)
    );

    assign m_tdata = {6'd0, o_z, o_y, o_x, o_col, o_node};
endmodule

FILE: tb/skeleton_world_matrix_compose_unit_checker.sv
`timescale 1ns / 1ps
module skeleton_world_matrix_compose_unit_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [231:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending
);

    localparam int NodeSpan = 256;
    localparam longint I32Max = 64'sd2147483647;
    localparam longint I32Min = -64'sd2147483648;

    typedef struct {
        logic [7:0]         node;
        logic [1:0]         col;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
        logic               last;
    } column_t;

    column_t column_q[$];
    longint  world_mem[NodeSpan * 12];
    int      node_idx;
    int      mismatches;

    const longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                   256, 128, 64, 32, 16, 8, 4, 2};

    function automatic longint clip32(longint v);
        if (v > I32Max) return I32Max;
        if (v < I32Min) return I32Min;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clip32((a * b) >>> 16);
    endfunction

    function automatic longint qadd(longint a, longint b);
        return clip32(a + b);
    endfunction

    function automatic longint qneg(longint a);
        return clip32(-a);
    endfunction

    // Folded CORDIC rotation; returns negated sine as the block uses it
    task automatic cordic(input logic signed [15:0] ang, output longint s, output longint c);
        longint z, x, y, nx, ny;
        bit     fold;
        z = longint'(ang) * 8;
        x = swmc_pkg::CordicGain;
        y = 0;
        fold = 0;
        if (z > swmc_pkg::QHalfPi) begin
            z -= swmc_pkg::QPi;
            fold = 1;
        end else if (z < -swmc_pkg::QHalfPi) begin
            z += swmc_pkg::QPi;
            fold = 1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_tab[i];
            end
            x = nx;
            y = ny;
        end
        if (fold) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = -y;
    endtask

    // Local matrix, world matrix and the four column transfers of one node
    task automatic compose_node(input logic [231:0] d);
        longint loc[4][3];
        longint wld[4][3];
        longint c0, s0, c1, s1, c2, s2, a, b, sum;
        longint sc[3];
        logic signed [8:0] par;
        int     pb;
        column_t col_item;
        if (d[0]) node_idx = 0;
        if (node_idx >= NodeSpan) node_idx = 0;
        par = d[9:1];
        cordic(d[26:11], s0, c0);
        cordic(d[42:27], s1, c1);
        cordic(d[58:43], s2, c2);
        if (d[10]) begin
            a = qmul(s0, s1);
            b = qmul(c0, s1);
            loc[0][0] = qmul(c1, c2);
            loc[1][0] = qneg(qmul(c1, s2));
            loc[2][0] = qneg(s1);
            loc[0][1] = qadd(qneg(qmul(a, c2)), qmul(c0, s2));
            loc[1][1] = qadd(qmul(a, s2), qmul(c0, c2));
            loc[2][1] = qneg(qmul(s0, c1));
            loc[0][2] = qadd(qmul(b, c2), qmul(s0, s2));
            loc[1][2] = qadd(qneg(qmul(b, s2)), qmul(s0, c2));
            loc[2][2] = qmul(c0, c1);
        end else begin
            a = qneg(qmul(c2, s1));
            b = qneg(qmul(s2, s1));
            loc[0][0] = qmul(c2, c1);
            loc[0][1] = qmul(s2, c1);
            loc[0][2] = s1;
            loc[1][0] = qadd(qneg(qmul(s2, c0)), qmul(a, s0));
            loc[1][1] = qadd(qmul(c2, c0), qmul(b, s0));
            loc[1][2] = qmul(c1, s0);
            loc[2][0] = qadd(qmul(s2, s0), qmul(a, c0));
            loc[2][1] = qadd(qneg(qmul(c2, s0)), qmul(b, c0));
            loc[2][2] = qmul(c1, c0);
        end
        sc[0] = longint'($signed(d[82:59]));
        sc[1] = longint'($signed(d[106:83]));
        sc[2] = longint'($signed(d[130:107]));
        for (int cl = 0; cl < 3; cl++)
            for (int r = 0; r < 3; r++)
                loc[cl][r] = qmul(loc[cl][r], sc[cl]);
        loc[3][0] = longint'($signed(d[162:131]));
        loc[3][1] = longint'($signed(d[194:163]));
        loc[3][2] = longint'($signed(d[226:195]));

        // Parent applies only if it came earlier in this skeleton
        if (par >= 0 && int'(par) < node_idx) begin
            pb = int'(par) * 12;
            for (int cl = 0; cl < 4; cl++)
                for (int r = 0; r < 3; r++) begin
                    sum = 0;
                    for (int k = 0; k < 3; k++)
                        sum += (world_mem[pb + k * 3 + r] * loc[cl][k]) >>> 16;
                    if (cl == 3) sum += world_mem[pb + 9 + r];
                    wld[cl][r] = clip32(sum);
                end
        end else begin
            wld = loc;
        end

        for (int cl = 0; cl < 4; cl++) begin
            for (int r = 0; r < 3; r++)
                world_mem[node_idx * 12 + cl * 3 + r] = wld[cl][r];
            col_item.node = node_idx[7:0];
            col_item.col  = cl[1:0];
            col_item.ex   = wld[cl][0][31:0];
            col_item.ey   = wld[cl][1][31:0];
            col_item.ez   = wld[cl][2][31:0];
            col_item.last = (cl == 3);
            column_q.push_back(col_item);
        end
        node_idx = node_idx + 1;
        if (node_idx >= NodeSpan) node_idx = 0;
    endtask

    // Watch both channels at the clock edge
    always @(posedge aclk) begin
        column_t want;
        if (!aresetn) begin
            node_idx = 0;
            column_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (column_q.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (mismatches < 10)
                        $display("unexpected column transfer %h", m_tdata);
                    mismatches = mismatches + 1;
                end else begin
                    want = column_q.pop_front();
                    if (m_tdata[7:0] !== want.node || m_tdata[9:8] !== want.col ||
                        m_tdata[41:10] !== want.ex || m_tdata[73:42] !== want.ey ||
                        m_tdata[105:74] !== want.ez || m_tlast !== want.last) begin
                        fail_count = fail_count + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp node %0d col %0d x %h y %h z %h last %b",
                                     want.node, want.col, want.ex, want.ey, want.ez,
                                     want.last, " / got node %0d col %0d x %h y %h z %h last %b",
                                     m_tdata[7:0], m_tdata[9:8], m_tdata[41:10],
                                     m_tdata[73:42], m_tdata[105:74], m_tlast);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                compose_node(s_tdata);
        end
        pending = column_q.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
        mismatches = 0;
        node_idx = 0;
    end

endmodule

FILE: tb/skeleton_world_matrix_compose_unit_test.sv
`timescale 1ns / 1ps
module skeleton_world_matrix_compose_unit_test;

    localparam int CycleLimit = 900000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [231:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic         m_tlast;
    int           fail_count;
    int           pending;
    int           cycles;
    int           burst_left;
    bit           hold_req;
    int           node_pos;

    skeleton_world_matrix_compose_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    skeleton_world_matrix_compose_unit_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: stall pattern with randomly chosen modes, plus one long hold
    initial begin
        int phase;
        int mode;
        phase = 0;
        mode = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (700) @(posedge aclk);
                hold_req = 0;
            end else begin
                if (phase % 64 == 0) mode = $urandom_range(0, 3);
                phase++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // One node transfer, with burst/gap shaping on the sender side
    task automatic send_node(input logic f, input logic signed [8:0] par, input logic ord,
                             input logic [15:0] rx, input logic [15:0] ry,
                             input logic [15:0] rz, input logic [23:0] sx,
                             input logic [23:0] sy, input logic [23:0] sz,
                             input logic [31:0] tx, input logic [31:0] ty,
                             input logic [31:0] tz);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 6);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, tz, ty, tx, sz, sy, sx, rz, ry, rx, ord, par, f};
        do @(posedge aclk); while (!s_tready);
        if (f) node_pos = 0;
        node_pos = (node_pos + 1) % 256;
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 25736)) - 12868);
            2: return 16'($urandom_range(0, 1) ? 32767 : 32768);
            default: return 16'($urandom_range(0, 400));
        endcase
    endfunction

    function automatic logic [23:0] rand_scale();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 1) ? 24'h7fffff : 24'h800000);
            2: return 24'(-65536 + $signed($urandom_range(0, 4096)) - 2048);
            default: return 24'(65536 + $signed($urandom_range(0, 65536)) - 32768);
        endcase
    endfunction

    function automatic logic [31:0] rand_trans();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    // Random node: mostly a valid earlier parent, sometimes root or bogus index
    task automatic random_node(input logic f);
        logic signed [8:0] par;
        int pos;
        pos = f ? 0 : node_pos;
        case ($urandom_range(0, 9))
            0: par = -9'sd1;
            1: par = 9'($urandom_range(0, 511));
            2: par = 9'(pos);
            default: par = (pos == 0) ? -9'sd1 : 9'($urandom_range(0, pos - 1));
        endcase
        send_node(f, par, 1'($urandom_range(0, 1)), rand_angle(), rand_angle(),
                  rand_angle(), rand_scale(), rand_scale(), rand_scale(),
                  rand_trans(), rand_trans(), rand_trans());
    endtask

    // Stop offering and wait until every predicted column has been seen
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int n;
        cycles = 0;
        burst_left = 0;
        hold_req = 0;
        node_pos = 0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: angle extremes and fold boundaries, both formula sets,
        // scale and translation extremes, roots and parent chains
        send_node(1, -9'sd1, 0, 16'd0, 16'd0, 16'd0, 24'd65536, 24'd65536, 24'd65536,
                  32'd0, 32'd0, 32'd0);
        send_node(0, 9'sd0, 1, 16'h7fff, 16'h8000, 16'd12868, 24'd65536, 24'd65536,
                  24'd65536, 32'h7fffffff, 32'h80000000, 32'd65536);
        send_node(0, 9'sd1, 0, 16'd12869, 16'hcdbc, 16'hcdbb, 24'h7fffff, 24'h800000,
                  24'd0, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_node(0, 9'sd2, 1, 16'd6000, 16'd3000, 16'hf000, 24'h7fffff, 24'h7fffff,
                  24'h800000, 32'h80000000, 32'd100, 32'h7fffffff);
        send_node(0, -9'sd256, 1, 16'h8000, 16'h7fff, 16'h7fff, 24'hffffff, 24'd1,
                  24'h800000, 32'hffffffff, 32'd1, 32'd0);
        send_node(0, 9'sd255, 0, 16'hcdbc, 16'd12869, 16'd0, 24'd65536, 24'd131072,
                  24'd32768, 32'd5, 32'd6, 32'd7);
        send_node(0, 9'sd6, 1, 16'd100, 16'd200, 16'd300, 24'd65536, 24'd65536,
                  24'd65536, 32'd0, 32'd0, 32'd0);
        send_node(0, 9'sd7, 0, 16'd12868, 16'hcdbc, 16'h8000, 24'h800000, 24'h7fffff,
                  24'h7fffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_node(0, 9'sd3, 1, 16'hffff, 16'd1, 16'hcdbb, 24'h7fffff, 24'h800000,
                  24'h7fffff, 32'h12345678, 32'h87654321, 32'h0000ffff);
        send_node(1, 9'sd0, 0, 16'd1000, 16'hfc18, 16'd5000, 24'd65536, 24'd65536,
                  24'd65536, 32'd65536, 32'd0, 32'd0);
        send_node(0, 9'sd0, 1, 16'd2000, 16'd2000, 16'd2000, 24'd65536, 24'd65536,
                  24'd65536, 32'd0, 32'd65536, 32'd0);
        send_node(0, 9'sd1, 0, 16'hd000, 16'h3000, 16'h5555, 24'haaaaaa, 24'h555555,
                  24'h123456, 32'haaaaaaaa, 32'h55555555, 32'h0f0f0f0f);
        wait_drained();

        // Sender pause until all results are back, then long receiver hold
        for (int i = 0; i < 4; i++) random_node(i == 0);
        wait_drained();
        hold_req = 1;
        for (int i = 0; i < 12; i++) random_node(0);

        // One skeleton long enough to wrap the node counter
        for (int i = 0; i < 262; i++) random_node(i == 0);

        // Random skeletons of small size
        n = 0;
        while (n < 130) begin
            int len;
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) random_node(i == 0);
            n += len;
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (300) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/swmc_pkg.sv
hdl/swmc_front.sv
hdl/swmc_back.sv
hdl/skeleton_world_matrix_compose_unit.sv
tb/skeleton_world_matrix_compose_unit_checker.sv
tb/skeleton_world_matrix_compose_unit_test.sv
